// ===== src/fag_pkg.sv =====
// Package for the fraction accumulator with gcd reduction.
// Holds mode codes and width defaults; no dependencies.
package fag_pkg;

   localparam int DataWidthDefault = 32;
   localparam int IoWidth = 32;

   // Item modes.
   localparam logic [1:0] MODE_LOAD     = 2'd0;
   localparam logic [1:0] MODE_ADD      = 2'd1;
   localparam logic [1:0] MODE_SUB      = 2'd2;
   localparam logic [1:0] MODE_SIMPLIFY = 2'd3;

endpackage

// ===== src/fag_divider.sv =====
// Shared signed divider, one quotient bit per cycle, truncating as C does.
// Depends on fag_pkg.
module fag_divider #(
   parameter int DATA_WIDTH = fag_pkg::DataWidthDefault
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic [DATA_WIDTH-1:0] dividend,
   input  logic [DATA_WIDTH-1:0] divisor,
   output logic                  done,
   output logic [DATA_WIDTH-1:0] quotient,
   output logic [DATA_WIDTH-1:0] remainder
);
   import fag_pkg::*;

   localparam int CntWidth = $clog2(DATA_WIDTH + 1);

   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   logic [CntWidth-1:0]   cnt_ff, cnt_in;
   logic [DATA_WIDTH-1:0] quo_ff, quo_in;
   logic [DATA_WIDTH-1:0] rem_ff, rem_in;
   logic [DATA_WIDTH-1:0] dsr_ff, dsr_in;
   logic                  qneg_ff, qneg_in;
   logic                  rneg_ff, rneg_in;
   logic [DATA_WIDTH:0]   trial;
   logic [DATA_WIDTH:0]   shifted;

   assign shifted = {rem_ff, quo_ff[DATA_WIDTH-1]};
   assign trial   = shifted - {1'b0, dsr_ff};

   // Restoring division on magnitudes; signs applied at the output.
   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dsr_in  = dsr_ff;
      qneg_in = qneg_ff;
      rneg_in = rneg_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CntWidth'(DATA_WIDTH);
         quo_in  = dividend[DATA_WIDTH-1] ? -dividend : dividend;
         dsr_in  = divisor[DATA_WIDTH-1] ? -divisor : divisor;
         rem_in  = '0;
         qneg_in = dividend[DATA_WIDTH-1] ^ divisor[DATA_WIDTH-1];
         rneg_in = dividend[DATA_WIDTH-1];
      end else if (busy_ff) begin
         if (!trial[DATA_WIDTH]) begin
            rem_in = trial[DATA_WIDTH-1:0];
            quo_in = {quo_ff[DATA_WIDTH-2:0], 1'b1};
         end else begin
            rem_in = shifted[DATA_WIDTH-1:0];
            quo_in = {quo_ff[DATA_WIDTH-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CntWidth'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      quo_ff  <= quo_in;
      rem_ff  <= rem_in;
      dsr_ff  <= dsr_in;
      qneg_ff <= qneg_in;
      rneg_ff <= rneg_in;
   end

   assign done      = done_ff;
   assign quotient  = qneg_ff ? -quo_ff : quo_ff;
   assign remainder = rneg_ff ? -rem_ff : rem_ff;

   // The count runs only while busy.
   assert property (@(posedge clock) disable iff (reset) !busy_ff |-> cnt_ff == '0 || start
                    || $past(start))
      else $error("divider count left over");
   assert property (@(posedge clock) disable iff (reset) done_ff |-> !busy_ff)
      else $error("divider done while busy");
   assert property (@(posedge clock) disable iff (reset) done_ff |=> !done_ff)
      else $error("divider done held");
endmodule

// ===== src/fraction_accumulator_gcd.sv =====
// Top level: fraction accumulator, sequencer and multiplier around one shared divider.
// Depends on fag_pkg and fag_divider.
//
// Usage: items enter on the req_ channel (tdata: op_numerator [31:0],
// op_denominator [63:32]; tuser: mode). Every item yields exactly one item on
// the rsp_ channel (tdata: res_numerator, res_denominator; tuser: div_error).
// The block takes one item at a time. Work is done by a single restoring
// divider producing one quotient bit per cycle. Simplify runs Euclid (one
// division per step, up to about 47 steps) plus two divisions. Add and sub
// run Euclid on the denominators plus three divisions and three multiplies.
// After reset the accumulator is 0/1 and req_tready goes high. The result
// waits in the output register while rsp_tready is low; the next item is
// accepted only once that result has been taken.
module fraction_accumulator_gcd #(
   parameter int DATA_WIDTH = fag_pkg::DataWidthDefault
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [63:0] req_tdata,   // op_numerator, op_denominator
   input  logic [1:0]  req_tuser,   // mode
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [63:0] rsp_tdata,   // res_numerator, res_denominator
   output logic        rsp_tuser    // div_error
);
   import fag_pkg::*;

   typedef enum logic [9:0] {
      ST_IDLE  = 10'b0000000001,
      ST_GCD   = 10'b0000000010,
      ST_GWAIT = 10'b0000000100,
      ST_DIV1  = 10'b0000001000,
      ST_W1    = 10'b0000010000,
      ST_DIV2  = 10'b0000100000,
      ST_W2    = 10'b0001000000,
      ST_DIV3  = 10'b0010000000,
      ST_W3    = 10'b0100000000,
      ST_OUT   = 10'b1000000000
   } state_type;

   localparam int W = DATA_WIDTH;

   state_type     state_ff, state_in;
   logic [W-1:0]  accn_ff, accn_in, accd_ff, accd_in;
   logic [W-1:0]  on_ff, on_in, od_ff, od_in;
   logic [1:0]    mode_ff, mode_in;
   logic [W-1:0]  ga_ff, ga_in, gb_ff, gb_in;
   logic [W-1:0]  t1_ff, t1_in, t2_ff, t2_in;
   logic          err_ff, err_in;
   logic          dstart;
   logic [W-1:0]  dnd, dsr, dq, dr;
   logic          ddone;
   logic [W-1:0]  mul_a, mul_b, mul_p;
   logic [W-1:0]  in_n, in_d;

   fag_divider #(.DATA_WIDTH(W)) u_div (
      .clock(clock), .reset(reset), .start(dstart), .dividend(dnd), .divisor(dsr),
      .done(ddone), .quotient(dq), .remainder(dr)
   );

   // Single wrapping multiplier; operands are registered values.
   assign mul_p = W'(mul_a * mul_b);

   assign in_n = W'($signed(req_tdata[31:0]));
   assign in_d = W'($signed(req_tdata[63:32]));

   // Sequencer.
   always_comb begin
      state_in = state_ff;
      accn_in = accn_ff; accd_in = accd_ff;
      on_in = on_ff; od_in = od_ff; mode_in = mode_ff;
      ga_in = ga_ff; gb_in = gb_ff; t1_in = t1_ff; t2_in = t2_ff;
      err_in = err_ff;
      dstart = 1'b0; dnd = '0; dsr = '1;
      mul_a = '0; mul_b = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               mode_in = req_tuser; on_in = in_n; od_in = in_d; err_in = 1'b0;
               if (req_tuser == MODE_LOAD) begin
                  accn_in = in_n; accd_in = in_d; state_in = ST_OUT;
               end else if (req_tuser == MODE_SIMPLIFY) begin
                  ga_in = accn_ff; gb_in = accd_ff; state_in = ST_GCD;
               end else begin
                  ga_in = accd_ff; gb_in = in_d; state_in = ST_GCD;
               end
            end
         end
         // Euclid: while a != 0, t = b rem a; b = a; a = t.
         ST_GCD: begin
            if (ga_ff == '0) begin
               if (gb_ff == '0 || (mode_ff != MODE_SIMPLIFY
                                   && (accd_ff == '0 || od_ff == '0))) begin
                  err_in = 1'b1; state_in = ST_OUT;
               end else if (mode_ff == MODE_SIMPLIFY) begin
                  dstart = 1'b1; dnd = accn_ff; dsr = gb_ff; state_in = ST_W1;
               end else begin
                  mul_a = accd_ff; mul_b = od_ff;
                  t1_in = mul_p; state_in = ST_DIV1;
               end
            end else begin
               dstart = 1'b1; dnd = gb_ff; dsr = ga_ff; state_in = ST_GWAIT;
            end
         end
         ST_GWAIT: begin
            dnd = gb_ff; dsr = ga_ff;
            if (ddone) begin
               gb_in = ga_ff; ga_in = dr; state_in = ST_GCD;
            end
         end
         // Add/sub: l = (d1*d2)/g.
         ST_DIV1: begin
            dstart = 1'b1; dnd = t1_ff; dsr = gb_ff; state_in = ST_W1;
         end
         ST_W1: begin
            if (ddone) begin
               if (mode_ff == MODE_SIMPLIFY) begin
                  t1_in = dq; dstart = 1'b1; dnd = accd_ff; dsr = gb_ff;
                  state_in = ST_W3;
               end else begin
                  ga_in = dq; state_in = ST_DIV2;
               end
            end
         end
         // x = l / accd, p = x * accn.
         ST_DIV2: begin
            dstart = 1'b1; dnd = ga_ff; dsr = accd_ff; state_in = ST_W2;
         end
         ST_W2: begin
            if (ddone) begin
               mul_a = dq; mul_b = accn_ff; t2_in = mul_p; state_in = ST_DIV3;
            end
         end
         // y = l / od, q = y * on.
         ST_DIV3: begin
            dstart = 1'b1; dnd = ga_ff; dsr = od_ff; state_in = ST_W3;
         end
         ST_W3: begin
            if (ddone) begin
               if (mode_ff == MODE_SIMPLIFY) begin
                  accn_in = t1_ff; accd_in = dq;
               end else begin
                  mul_a = dq; mul_b = on_ff;
                  accn_in = (mode_ff == MODE_ADD) ? t2_ff + mul_p : t2_ff - mul_p;
                  accd_in = ga_ff;
               end
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            if (rsp_tready) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         accn_ff  <= '0;
         accd_ff  <= W'(1);
         err_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         accn_ff  <= accn_in;
         accd_ff  <= accd_in;
         err_ff   <= err_in;
      end
      on_ff <= on_in; od_ff <= od_in; mode_ff <= mode_in;
      ga_ff <= ga_in; gb_ff <= gb_in; t1_ff <= t1_in; t2_ff <= t2_in;
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = (state_ff == ST_OUT);
   assign rsp_tdata  = {IoWidth'($signed(accd_ff)), IoWidth'($signed(accn_ff))};
   assign rsp_tuser  = err_ff;

   assert property (@(posedge clock) disable iff (reset) rsp_tvalid |-> !req_tready)
      else $error("ready during result");
   assert property (@(posedge clock) disable iff (reset)
                    rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result changed while stalled");
   assert property (@(posedge clock) disable iff (reset)
                    req_tvalid && req_tready && req_tuser == MODE_LOAD |=> rsp_tvalid)
      else $error("load not answered next cycle");
   assert property (@(posedge clock) disable iff (reset)
                    rsp_tuser && rsp_tvalid && $past(state_ff) == ST_GCD |-> $stable(accn_ff))
      else $error("error changed state");
endmodule

// ===== test/testbench.sv =====
// Self-checking testbench for fraction_accumulator_gcd: directed and random items
// checked against an in-bench fraction predictor. Depends on fag_pkg and the RTL.
module testbench;
   timeunit 1ns;
   timeprecision 1ps;
   import fag_pkg::*;

   // Tracks the expected accumulator and the queue of expected results.
   class fraction_scoreboard;
      logic [31:0] acc_num;
      logic [31:0] acc_den;
      logic [64:0] pending[$];
      int fail_count;

      function new();
         acc_num = 0;
         acc_den = 1;
         fail_count = 0;
      endfunction

      function logic [31:0] neg_of(logic [31:0] x);
         return 32'd0 - x;
      endfunction

      function logic [31:0] mag_of(logic [31:0] x);
         return x[31] ? neg_of(x) : x;
      endfunction

      function logic [31:0] quot(logic [31:0] a, logic [31:0] b);
         logic [31:0] q;
         q = mag_of(a) / mag_of(b);
         return (a[31] != b[31]) ? neg_of(q) : q;
      endfunction

      function logic [31:0] remainder(logic [31:0] a, logic [31:0] b);
         logic [31:0] r;
         r = mag_of(a) % mag_of(b);
         return a[31] ? neg_of(r) : r;
      endfunction

      function logic [31:0] euclid(logic [31:0] a, logic [31:0] b);
         logic [31:0] t;
         while (a != 0) begin
            t = remainder(b, a);
            b = a;
            a = t;
         end
         return b;
      endfunction

      // Applies one accepted item to the predicted accumulator.
      function void note_item(logic [1:0] mode, logic [31:0] on, logic [31:0] od);
         logic err;
         logic [31:0] g, l, x, y, p, q;
         err = 1'b0;
         if (mode == MODE_LOAD) begin
            acc_num = on;
            acc_den = od;
         end else if (mode == MODE_ADD || mode == MODE_SUB) begin
            g = euclid(acc_den, od);
            if (g == 0 || acc_den == 0 || od == 0) begin
               err = 1'b1;
            end else begin
               l = quot(acc_den * od, g);
               x = quot(l, acc_den);
               y = quot(l, od);
               p = x * acc_num;
               q = y * on;
               acc_num = (mode == MODE_ADD) ? p + q : p - q;
               acc_den = l;
            end
         end else begin
            g = euclid(acc_num, acc_den);
            if (g == 0) begin
               err = 1'b1;
            end else begin
               acc_num = quot(acc_num, g);
               acc_den = quot(acc_den, g);
            end
         end
         pending.push_back({err, acc_den, acc_num});
      endfunction

      // Compares one result item with the oldest expectation.
      function void check_result(logic [63:0] data, logic user);
         logic [64:0] e;
         if (pending.size() == 0) begin
            $error("unexpected result item %h", data);
            fail_count++;
            return;
         end
         e = pending.pop_front();
         if (data[31:0] !== e[31:0]) begin
            $error("res_numerator expected %h actual %h", e[31:0], data[31:0]);
            fail_count++;
         end
         if (data[63:32] !== e[63:32]) begin
            $error("res_denominator expected %h actual %h", e[63:32], data[63:32]);
            fail_count++;
         end
         if (user !== e[64]) begin
            $error("div_error expected %b actual %b", e[64], user);
            fail_count++;
         end
      endfunction
   endclass

   logic clock, reset;
   logic req_tvalid, req_tready, rsp_tvalid, rsp_tready, rsp_tuser;
   logic [63:0] req_tdata, rsp_tdata;
   logic [1:0] req_tuser;
   logic quiet_phase, hold_off;
   fraction_scoreboard fractions;

   fraction_accumulator_gcd uut (.*);

   initial begin
      clock = 0;
      forever #1 clock = ~clock;
   end

   initial begin
      #50ms;
      $display("TEST FAILED");
      $finish;
   end

   // Picks an interesting 32-bit value, mostly small.
   function automatic logic [31:0] pick_value();
      case ($urandom_range(0, 9))
         0: return 32'h8000_0000;
         1: return 32'h7fff_ffff;
         2: return 32'hffff_ffff;
         3: return 0;
         4: return $urandom;
         default: return $urandom_range(0, 40) - 20;
      endcase
   endfunction

   // Offers one item and waits for acceptance; valid stays up until the next call.
   task automatic send_item(logic [1:0] mode, logic [31:0] on, logic [31:0] od);
      int gap;
      if (!quiet_phase && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 6);
         req_tvalid <= 0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1;
      req_tuser <= mode;
      req_tdata <= {od, on};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      fractions.note_item(mode, on, od);
   endtask

   // Result side: random stalls, plus a long hold-off on request.
   initial begin
      rsp_tready = 0;
      forever begin
         @(posedge clock);
         if (hold_off) begin
            rsp_tready <= 0;
            repeat (4000) @(posedge clock);
            hold_off = 0;
         end
         if (!quiet_phase && $urandom_range(0, 7) == 0) begin
            rsp_tready <= 0;
            repeat ($urandom_range(1, 6)) @(posedge clock);
            rsp_tready <= 1;
         end else begin
            rsp_tready <= quiet_phase || ($urandom_range(0, 3) != 0);
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) fractions.check_result(rsp_tdata, rsp_tuser);
   end

   initial begin
      int k;
      fractions = new();
      quiet_phase = 0;
      hold_off = 0;
      reset = 1;
      req_tvalid = 0;
      req_tdata = 0;
      req_tuser = MODE_LOAD;
      repeat (6) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      // Directed: each mode, zero denominators, extremes, min over minus one.
      send_item(MODE_SIMPLIFY, 0, 0);
      send_item(MODE_ADD, 1, 2);
      send_item(MODE_SUB, 3, 4);
      send_item(MODE_SIMPLIFY, 0, 0);
      send_item(MODE_ADD, 5, 0);
      send_item(MODE_LOAD, 7, 0);
      send_item(MODE_ADD, 1, 3);
      send_item(MODE_LOAD, 0, 0);
      send_item(MODE_SIMPLIFY, 0, 0);
      send_item(MODE_ADD, 1, 0);
      send_item(MODE_LOAD, 32'h8000_0000, 32'hffff_ffff);
      send_item(MODE_SIMPLIFY, 0, 0);
      send_item(MODE_LOAD, 32'h7fff_ffff, 32'h8000_0000);
      send_item(MODE_ADD, 32'h8000_0000, 32'h7fff_ffff);
      send_item(MODE_LOAD, -6, 4);
      send_item(MODE_SUB, 32'hffff_ffff, -6);
      send_item(MODE_SIMPLIFY, 0, 0);
      send_item(MODE_LOAD, 32'hffff_ffff, 32'hffff_ffff);
      send_item(MODE_SIMPLIFY, 0, 0);
      // Long receiver hold-off while items keep coming.
      hold_off = 1;
      for (k = 0; k < 5; k++) send_item(MODE_ADD, k + 1, k + 2);
      // Sender pauses until all results are back.
      req_tvalid <= 0;
      while (fractions.pending.size() != 0) @(posedge clock);
      // Random part: mostly short load/add/sub/simplify sequences.
      for (k = 0; k < 350; k++) begin
         if (k == 300) quiet_phase = 1;
         if (k % 8 == 0) send_item(MODE_LOAD, pick_value(), pick_value());
         else send_item(2'($urandom_range(0, 3)), pick_value(), pick_value());
      end
      req_tvalid <= 0;
      while (fractions.pending.size() != 0) @(posedge clock);
      repeat (50) @(posedge clock);
      if (fractions.fail_count == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end
endmodule
